### rtl/selrc_pkg.sv
// Shared types, character codes and helper functions for the framed message receiver.
// Used by every module of the receiver; depends on nothing else.
package selrc_pkg;

    localparam int MAX_FRAME_DEF = 1024;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 10;
    localparam int DECL_W = 14;
    localparam int VERD_W = 3;
    localparam int ODATA_W = 40;

    localparam logic [LEN_W-1:0] MAX_LEN_RST = 10'd1019;

    localparam logic [BYTE_W-1:0] CH_STX = 8'h02;
    localparam logic [BYTE_W-1:0] CH_ETX = 8'h03;
    localparam logic [BYTE_W-1:0] CH_ACK = 8'h06;
    localparam logic [BYTE_W-1:0] CH_NAK = 8'h15;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_IDLE = 1'b1;

    localparam logic OKIND_DATA    = 1'b0;
    localparam logic OKIND_VERDICT = 1'b1;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef enum logic [VERD_W-1:0] {
        VD_OK      = 3'd0,
        VD_BAD_ETX = 3'd1,
        VD_BAD_LRC = 3'd2,
        VD_BAD_LEN = 3'd3,
        VD_GAP     = 3'd4
    } t_verdict;

    typedef enum logic [5:0] {
        PH_HUNT   = 6'b000001,
        PH_LEN_HI = 6'b000010,
        PH_LEN_LO = 6'b000100,
        PH_DATA   = 6'b001000,
        PH_ETX    = 6'b010000,
        PH_LRC    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic              is_verdict;
        logic [BYTE_W-1:0] data;
        logic [LEN_W-1:0]  index;
        t_verdict          verdict;
        logic [LEN_W-1:0]  length;
    } t_cmd;

    function automatic logic bcd_ok(input logic [BYTE_W-1:0] b);
        return (b[7:4] <= 4'd9) && (b[3:0] <= 4'd9);
    endfunction

    function automatic logic [6:0] bcd_val(input logic [BYTE_W-1:0] b);
        logic [6:0] tens;
        tens = {3'd0, b[7:4]};
        return 7'((tens << 3) + (tens << 1) + {3'd0, b[3:0]});
    endfunction

endpackage

### rtl/stx_etx_lrc_frame_receiver_unit.sv
// Results pass through the command queue and then the output register after the input
// byte that causes them. Throughput: one input event per cycle while the queue is not
// full, set by the parser step and a two-entry command queue that decouples the parser
// from the output register. Reset (synchronous, active low) returns the parser to STX
// hunting, empties the queue and output register, and loads the length limit with 1019.
module stx_etx_lrc_frame_receiver_unit
    import selrc_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LEN_W-1:0]   i_cfg_wdata,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [BYTE_W-1:0]  s_axis_tdata,   // [7:0] rx_byte
    input  logic               s_axis_tuser,   // [0] kind
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [7:0] payload_byte, [17:8] payload_index, [20:18] verdict,
    // [28:21] reply_byte, [38:29] frame_length, [39] zero
    output logic [ODATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tuser,   // [0] out_kind
    output logic               m_axis_tlast
);

    logic q_full;
    logic q_empty;
    logic q_pop;
    logic cmd_valid;
    t_cmd cmd_in;
    t_cmd cmd_out;

    selrc_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_kind      (s_axis_tuser),
        .i_byte      (s_axis_tdata),
        .i_q_full    (q_full),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd_in)
    );

    selrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_valid),
        .i_cmd   (cmd_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (cmd_out)
    );

    selrc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (cmd_out),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_user    (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

endmodule

### rtl/selrc_front.sv
// Front part of the receiver: frame parser that classifies each incoming event.
// Depends on selrc_pkg; feeds commands into selrc_queue.
module selrc_front
    import selrc_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [LEN_W-1:0]  i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_kind,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_q_full,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd
);

    localparam logic [DECL_W-1:0] LEN_CAP = DECL_W'(MAX_FRAME - 5);

    t_phase             r_phase, n_phase;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_cnt, n_cnt;
    logic [BYTE_W-1:0]  r_lrc, n_lrc;
    logic [6:0]         r_hi_val, n_hi_val;
    logic               r_hi_ok, n_hi_ok;
    logic [LEN_W-1:0]   r_max_len;

    logic               accept;
    logic               emit;
    t_cmd               cmd;
    logic [DECL_W-1:0]  decl;
    logic [DECL_W-1:0]  limit;
    logic [LEN_W:0]     cnt_inc;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        decl  = DECL_W'({7'd0, r_hi_val} * 14'd100) + DECL_W'(bcd_val(i_byte));
        limit = ({4'd0, r_max_len} > LEN_CAP) ? LEN_CAP : {4'd0, r_max_len};
        cnt_inc = {1'b0, r_cnt} + 11'd1;
    end

    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_cnt    = r_cnt;
        n_lrc    = r_lrc;
        n_hi_val = r_hi_val;
        n_hi_ok  = r_hi_ok;
        emit     = 1'b0;
        cmd      = '{is_verdict: 1'b1, data: '0, index: '0, verdict: VD_OK, length: r_len};

        if (i_kind == KIND_IDLE) begin
            if (r_phase != PH_HUNT && r_phase != 6'd0) begin
                emit        = 1'b1;
                cmd.verdict = VD_GAP;
                n_phase     = PH_HUNT;
            end
        end else begin
            unique case (r_phase)
                PH_LEN_HI: begin
                    n_hi_val = bcd_val(i_byte);
                    n_hi_ok  = bcd_ok(i_byte);
                    n_lrc    = r_lrc ^ i_byte;
                    n_phase  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_lrc = r_lrc ^ i_byte;
                    if (!r_hi_ok || !bcd_ok(i_byte)) begin
                        emit        = 1'b1;
                        cmd.verdict = VD_BAD_LEN;
                        cmd.length  = '0;
                        n_len       = '0;
                        n_phase     = PH_HUNT;
                    end else if (decl > limit) begin
                        emit        = 1'b1;
                        cmd.verdict = VD_BAD_LEN;
                        cmd.length  = decl[LEN_W-1:0];
                        n_len       = decl[LEN_W-1:0];
                        n_phase     = PH_HUNT;
                    end else begin
                        n_len   = decl[LEN_W-1:0];
                        n_cnt   = '0;
                        n_phase = (decl == '0) ? PH_ETX : PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_lrc          = r_lrc ^ i_byte;
                    emit           = 1'b1;
                    cmd.is_verdict = 1'b0;
                    cmd.data       = i_byte;
                    cmd.index      = r_cnt;
                    cmd.length     = '0;
                    n_cnt          = cnt_inc[LEN_W-1:0];
                    if (cnt_inc >= {1'b0, r_len}) begin
                        n_phase = PH_ETX;
                    end
                end
                PH_ETX: begin
                    if (i_byte != CH_ETX) begin
                        emit        = 1'b1;
                        cmd.verdict = VD_BAD_ETX;
                        n_phase     = PH_HUNT;
                    end else begin
                        n_lrc   = r_lrc ^ i_byte;
                        n_phase = PH_LRC;
                    end
                end
                PH_LRC: begin
                    emit        = 1'b1;
                    cmd.verdict = ((r_lrc ^ i_byte) == '0) ? VD_OK : VD_BAD_LRC;
                    n_phase     = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                    if (i_byte == CH_STX) begin
                        n_phase = PH_LEN_HI;
                        n_lrc   = '0;
                        n_cnt   = '0;
                        n_len   = '0;
                    end
                end
            endcase
        end
    end

    assign o_cmd_valid = accept && emit;
    assign o_cmd       = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_len     <= '0;
            r_cnt     <= '0;
            r_lrc     <= '0;
            r_hi_val  <= '0;
            r_hi_ok   <= 1'b0;
            r_max_len <= MAX_LEN_RST;
        end else begin
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
            if (accept) begin
                r_phase  <= n_phase;
                r_len    <= n_len;
                r_cnt    <= n_cnt;
                r_lrc    <= n_lrc;
                r_hi_val <= n_hi_val;
                r_hi_ok  <= n_hi_ok;
            end
        end
    end

endmodule

### rtl/selrc_queue.sv
// Short command queue between the parser and the output stage.
// Depends on selrc_pkg for the command type and queue depth.
module selrc_queue
    import selrc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wptr;
    logic [Q_AW-1:0]   r_rptr;
    logic [Q_AW:0]     r_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

### rtl/selrc_back.sv
// Back part of the receiver: turns queued commands into result transactions.
// Depends on selrc_pkg; drains selrc_queue into the output register.
module selrc_back
    import selrc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_cmd               i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [ODATA_W-1:0] o_data,
    output logic               o_user,
    output logic               o_last
);

    logic               r_valid;
    logic [ODATA_W-1:0] r_data, n_data;
    logic               r_user;
    logic               r_last;
    logic [BYTE_W-1:0]  reply;

    assign o_pop = !i_q_empty && (!r_valid || i_ready);

    always_comb begin
        reply = '0;
        if (i_cmd.is_verdict) begin
            reply = (i_cmd.verdict == VD_OK) ? CH_ACK : CH_NAK;
        end
        n_data = {1'b0, i_cmd.length, reply, i_cmd.verdict, i_cmd.index, i_cmd.data};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
            r_user <= i_cmd.is_verdict ? OKIND_VERDICT : OKIND_DATA;
            r_last <= i_cmd.is_verdict;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;
    assign o_last  = r_last;

endmodule
